// ===== hw/rtl/tipm_pkg.sv =====
// Shared types, request codes and register indexes of the two-input pulse merger.
package tipm_pkg;

  localparam int ADDR_BITS_DEFAULT = 6;
  localparam int REQ_BITS          = 3;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 1;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_OVERWRITE   = 3'd0,
    REQ_NONBLOCKING = 3'd1,
    REQ_READ        = 3'd2,
    REQ_RISE        = 3'd3,
    REQ_FALL        = 3'd4
  } req_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MERGE_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_SELECT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_MODE    = 2'd2;

  typedef struct packed {
    logic merge_enable;
    logic input_select;
    logic slow_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/two_input_pulse_merger_unit.sv =====
// Top level of the two-input pulse merger: request and result registers around the core.
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  ----------------------------------------
//   config   cfg_wr_en                  cfg_index, cfg_data
//   request  in_valid / in_stall        req_type, port, pulse_addr_in
//   result   out_valid / out_stall      success, pulse_addr_out, overwrote
//
// Every request gives exactly one result: it lands in the request register, then,
// when the result register can take it, runs through the core's single pass of
// flag tests and register moves, and its result goes into the result register.
// A request can be accepted whenever in_stall is low, so the sustained rate is one
// request per cycle while the result side does not stall.
// The synchronous reset clears the configuration, all merger state and both
// valid flags directly; there is no clearing pass.
// A stall on the result side freezes a full result register and, once the request
// register is also full, raises in_stall in the same cycle.
module two_input_pulse_merger_unit
  import tipm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_BITS-1:0]       req_type,
  input  logic                      port,
  input  logic [ADDR_BITS-1:0]      pulse_addr_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      success,
  output logic [ADDR_BITS-1:0]      pulse_addr_out,
  output logic                      overwrote
);

  cfg_t cfg;

  // Request register.
  logic                 req_valid;
  logic [REQ_BITS-1:0]  req_code;
  logic                 req_port;
  logic [ADDR_BITS-1:0] req_addr;

  // The core runs the held request whenever the result register can take it.
  logic                 advance;
  logic                 step;
  logic                 res_success;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 res_overwrote;

  assign advance  = !out_valid || !out_stall;
  assign step     = req_valid && advance;
  assign in_stall = req_valid && !advance;

  tipm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tipm_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (step),
    .req           (req_code),
    .port          (req_port),
    .addr          (req_addr),
    .res_success   (res_success),
    .res_addr      (res_addr),
    .res_overwrote (res_overwrote)
  );

  // The request register refills whenever it is empty or drains this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_code <= req_type;
      req_port <= port;
      req_addr <= pulse_addr_in;
    end
  end

  // Result register; it holds a valid result while the result side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      success        <= res_success;
      pulse_addr_out <= res_addr;
      overwrote      <= res_overwrote;
    end
  end

endmodule

// ===== hw/rtl/tipm_cfg_regs.sv =====
// Configuration register file of the pulse merger.
module tipm_cfg_regs
  import tipm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MERGE_ENABLE: cfg.merge_enable <= cfg_data[0];
        CFG_INPUT_SELECT: cfg.input_select <= cfg_data[0];
        CFG_SLOW_MODE:    cfg.slow_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tipm_core.sv =====
// Merger state registers and the single-pass request logic that updates them.
module tipm_core
  import tipm_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 step,
  input  logic [REQ_BITS-1:0]  req,
  input  logic                 port,
  input  logic [ADDR_BITS-1:0] addr,
  output logic                 res_success,
  output logic [ADDR_BITS-1:0] res_addr,
  output logic                 res_overwrote
);

  logic [1:0][ADDR_BITS-1:0] in_data, in_data_next;
  logic [1:0]                in_full, in_full_next;
  logic [ADDR_BITS-1:0]      out_data, out_data_next;
  logic                      out_full, out_full_next;
  logic                      last_served, last_served_next;
  logic                      slow_hold, slow_hold_next;
  logic                      moved_this_cycle, moved_this_cycle_next;

  always_comb begin
    logic do_xfer;
    logic found;
    logic pick;
    logic other;

    in_data_next          = in_data;
    in_full_next          = in_full;
    out_data_next         = out_data;
    out_full_next         = out_full;
    last_served_next      = last_served;
    slow_hold_next        = slow_hold;
    moved_this_cycle_next = moved_this_cycle;
    res_success           = 1'b0;
    res_addr              = '0;
    res_overwrote         = 1'b0;
    do_xfer               = 1'b0;
    found                 = 1'b0;
    pick                  = 1'b0;
    other                 = ~last_served;

    case (req)
      REQ_OVERWRITE, REQ_NONBLOCKING: begin
        if (cfg.merge_enable || (port == cfg.input_select)) begin
          if (in_full[port]) begin
            if (req == REQ_OVERWRITE) begin
              in_data_next[port] = addr;
              res_overwrote      = 1'b1;
            end
          end else begin
            in_data_next[port] = addr;
            in_full_next[port] = 1'b1;
            res_success        = 1'b1;
          end
        end
      end
      REQ_READ: begin
        if (out_full && !moved_this_cycle) begin
          res_addr      = out_data;
          out_data_next = '0;
          out_full_next = 1'b0;
          res_success   = 1'b1;
          do_xfer       = 1'b1;
        end
      end
      REQ_RISE: begin
        do_xfer = !out_full;
      end
      REQ_FALL: begin
        moved_this_cycle_next = 1'b0;
      end
      default: begin
      end
    endcase

    // At most one move into the output register until a REQ_FALL request clears the moved flag.
    if (do_xfer && !moved_this_cycle) begin
      if (slow_hold) begin
        slow_hold_next = 1'b0;
      end else if (!out_full_next) begin
        if (cfg.merge_enable) begin
          if (in_full[other]) begin
            pick  = other;
            found = 1'b1;
          end else if (in_full[last_served]) begin
            pick  = last_served;
            found = 1'b1;
          end
        end else if (in_full[cfg.input_select]) begin
          pick  = cfg.input_select;
          found = 1'b1;
        end
        if (found) begin
          out_data_next      = in_data[pick];
          out_full_next      = 1'b1;
          in_full_next[pick] = 1'b0;
          last_served_next   = pick;
          if (cfg.slow_mode) begin
            slow_hold_next = 1'b1;
          end
        end
      end
      moved_this_cycle_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data          <= '0;
      in_full          <= '0;
      out_data         <= '0;
      out_full         <= 1'b0;
      last_served      <= 1'b1;
      slow_hold        <= 1'b0;
      moved_this_cycle <= 1'b0;
    end else if (step) begin
      in_data          <= in_data_next;
      in_full          <= in_full_next;
      out_data         <= out_data_next;
      out_full         <= out_full_next;
      last_served      <= last_served_next;
      slow_hold        <= slow_hold_next;
      moved_this_cycle <= moved_this_cycle_next;
    end
  end

  a_fall_clears_moved: assert property (@(posedge clk) disable iff (rst)
    (step && req == REQ_FALL) |=> !moved_this_cycle)
    else $error("falling edge did not clear the once-per-cycle flag");

  a_read_marks_moved: assert property (@(posedge clk) disable iff (rst)
    (step && req == REQ_READ && out_full && !moved_this_cycle) |=> moved_this_cycle)
    else $error("successful read did not use up the cycle's transfer");

  a_no_hold_without_slow: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.slow_mode && !slow_hold) |=> !slow_hold)
    else $error("slow hold set while slow mode is off");

  a_fill_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    step |=> ($countones(in_full) <= $countones($past(in_full)) + 1))
    else $error("more than one input register filled by one request");

endmodule
